// ----- rtl/core/wfc_pkg.sv -----
// shared constants and controller/datapath interface types for the word frequency counter
package wfc_pkg;

  localparam int DEF_TABLE_ENTRIES   = 256;
  localparam int DEF_WORD_BUFFER_LEN = 64;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;

  typedef struct packed {
    logic accept;
    logic search_init;
    logic next_entry;
    logic k_clr;
    logic k_inc;
    logic cp_wr;
    logic hit_wr;
    logic ins_wr;
    logic drop;
  } cmd_t;

  typedef struct packed {
    logic word_end;
    logic len_eq;
    logic let_eq;
    logic last_k;
    logic last_e;
    logic used_zero;
    logic full;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/core/wfc_ram.sv -----
// generic simple dual-port ram with registered read
module wfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/wfc_ctrl.sv -----
// controller state machine sequencing word build, table search, update and insert
module wfc_ctrl import wfc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LEN_RD  = 4'd1;
  localparam logic [3:0] S_LEN_CHK = 4'd2;
  localparam logic [3:0] S_LET_RD  = 4'd3;
  localparam logic [3:0] S_LET_CHK = 4'd4;
  localparam logic [3:0] S_HIT     = 4'd5;
  localparam logic [3:0] S_MISS    = 4'd6;
  localparam logic [3:0] S_CP_RD   = 4'd7;
  localparam logic [3:0] S_CP_WR   = 4'd8;
  localparam logic [3:0] S_INS     = 4'd9;
  localparam logic [3:0] S_DROP    = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.word_end) begin
            cmd.search_init = 1'b1;
            state_next = sts.used_zero ? S_MISS : S_LEN_RD;
          end
        end
      end
      S_LEN_RD: state_next = S_LEN_CHK;
      S_LEN_CHK: begin
        if (sts.len_eq) begin
          cmd.k_clr = 1'b1;
          state_next = S_LET_RD;
        end else begin
          cmd.next_entry = 1'b1;
          state_next = sts.last_e ? S_MISS : S_LEN_RD;
        end
      end
      S_LET_RD: state_next = S_LET_CHK;
      S_LET_CHK: begin
        if (!sts.let_eq) begin
          cmd.next_entry = 1'b1;
          state_next = sts.last_e ? S_MISS : S_LEN_RD;
        end else if (sts.last_k) begin
          state_next = S_HIT;
        end else begin
          cmd.k_inc = 1'b1;
          state_next = S_LET_RD;
        end
      end
      S_HIT: begin
        if (sts.out_free) begin
          cmd.hit_wr = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MISS: begin
        if (sts.full) begin
          state_next = S_DROP;
        end else begin
          cmd.k_clr = 1'b1;
          state_next = S_CP_RD;
        end
      end
      S_CP_RD: state_next = S_CP_WR;
      S_CP_WR: begin
        cmd.cp_wr = 1'b1;
        if (sts.last_k) begin
          state_next = S_INS;
        end else begin
          cmd.k_inc = 1'b1;
          state_next = S_CP_RD;
        end
      end
      S_INS: begin
        if (sts.out_free) begin
          cmd.ins_wr = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DROP: begin
        if (sts.out_free) begin
          cmd.drop = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/wfc_datapath.sv -----
// datapath: word buffer, word table memories, search counters and result register
module wfc_datapath import wfc_pkg::*; #(
  parameter int TABLE_ENTRIES   = DEF_TABLE_ENTRIES,
  parameter int WORD_BUFFER_LEN = DEF_WORD_BUFFER_LEN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_data
);

  localparam int MAX_LETTERS = WORD_BUFFER_LEN - 1;
  localparam int LW  = $clog2(WORD_BUFFER_LEN);
  localparam int CAW = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
  localparam int EW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int UW  = $clog2(TABLE_ENTRIES + 1);
  localparam int LDEPTH = TABLE_ENTRIES * MAX_LETTERS;
  localparam int LAW = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;

  logic [LW-1:0]  cur_len;
  logic [LW-1:0]  len_new;
  logic [LW-1:0]  k;
  logic [EW-1:0]  e;
  logic [UW-1:0]  used;
  logic [LAW-1:0] base;
  logic           is_letter;
  logic [4:0]     code;
  logic           append;
  logic [4:0]     cur_q;
  logic [4:0]     ent_q;
  logic [LW-1:0]  elen_q;
  logic [31:0]    cnt_q;
  logic [31:0]    cnt_wr;
  logic [LAW-1:0] let_addr;

  always_comb begin
    is_letter = 1'b0;
    code = 5'd0;
    if (text_byte >= CHAR_UPPER_A && text_byte <= CHAR_UPPER_Z) begin
      is_letter = 1'b1;
      code = 5'(text_byte - CHAR_UPPER_A);
    end else if (text_byte >= CHAR_LOWER_A && text_byte <= CHAR_LOWER_Z) begin
      is_letter = 1'b1;
      code = 5'(text_byte - CHAR_LOWER_A);
    end
  end

  assign append  = cmd.accept && is_letter && (cur_len < LW'(MAX_LETTERS));
  assign len_new = append ? cur_len + 1'b1 : cur_len;
  assign let_addr = base + LAW'(k);
  assign cnt_wr  = cmd.ins_wr ? 32'd1 : ((&cnt_q) ? cnt_q : cnt_q + 32'd1);

  assign sts.word_end  = (!is_letter || end_of_text) && (len_new != '0);
  assign sts.len_eq    = (elen_q == cur_len);
  assign sts.let_eq    = (ent_q == cur_q);
  assign sts.last_k    = ((k + 1'b1) == cur_len);
  assign sts.last_e    = ((UW'(e) + 1'b1) == used);
  assign sts.used_zero = (used == '0);
  assign sts.full      = (used == UW'(TABLE_ENTRIES));
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_len <= '0;
      used    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        cur_len <= len_new;
      end
      if (cmd.hit_wr || cmd.ins_wr || cmd.drop) begin
        cur_len <= '0;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.ins_wr) begin
        used <= used + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      e <= '0;
      base <= '0;
      k <= '0;
    end
    if (cmd.next_entry) begin
      e <= e + 1'b1;
      base <= base + LAW'(MAX_LETTERS);
      k <= '0;
    end
    if (cmd.k_clr) begin
      k <= '0;
    end
    if (cmd.k_inc) begin
      k <= k + 1'b1;
    end
    if (cmd.hit_wr) begin
      out_data <= {6'd0, 1'b0, 1'b0, cnt_wr, 8'(e)};
    end else if (cmd.ins_wr) begin
      out_data <= {6'd0, 1'b0, 1'b1, 32'd1, 8'(e)};
    end else if (cmd.drop) begin
      out_data <= {6'd0, 1'b1, 1'b0, 32'd0, 8'd0};
    end
  end

  wfc_ram #(.WIDTH(5), .DEPTH(MAX_LETTERS), .AW(CAW)) u_cur_ram (
    .clk     (clk),
    .wr_en   (append),
    .wr_addr (cur_len[CAW-1:0]),
    .wr_data (code),
    .rd_addr (k[CAW-1:0]),
    .rd_data (cur_q)
  );

  wfc_ram #(.WIDTH(5), .DEPTH(LDEPTH), .AW(LAW)) u_let_ram (
    .clk     (clk),
    .wr_en   (cmd.cp_wr),
    .wr_addr (let_addr),
    .wr_data (cur_q),
    .rd_addr (let_addr),
    .rd_data (ent_q)
  );

  wfc_ram #(.WIDTH(LW), .DEPTH(TABLE_ENTRIES), .AW(EW)) u_len_ram (
    .clk     (clk),
    .wr_en   (cmd.ins_wr),
    .wr_addr (e),
    .wr_data (cur_len),
    .rd_addr (e),
    .rd_data (elen_q)
  );

  wfc_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES), .AW(EW)) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cmd.hit_wr || cmd.ins_wr),
    .wr_addr (e),
    .wr_data (cnt_wr),
    .rd_addr (e),
    .rd_data (cnt_q)
  );

endmodule

// ----- rtl/core/word_frequency_counter_unit.sv -----
// top level of the streaming word frequency counter
// Usage:
// Text enters on the s_axis channel, one byte per transaction; s_axis_tlast marks
// the last byte of the text and flushes a pending word. Letters are lowercased and
// buffered (letters past the buffer limit are dropped); any other byte ends a word.
// Each completed word yields one transaction on m_axis with its table slot, count
// after update (saturating), a new-word flag and a table-full drop flag.
// Sequence: a letter goes straight into the word buffer. A word end scans the
// table: for each entry the length is read and checked, and where the lengths
// agree each letter is read and compared; a miss is then decided, on insert each
// letter is read and copied, and the result is posted once the output register
// is free. The search runs over stored entries through one letter memory read port.
// s_axis_tready is low while a word is searched, stored or dropped, and while its result waits for the output register.
// A finished result waits in an output register; if the receiver stalls, new
// letters are still accepted, and the next word end waits for the register.
// Reset clears the word length, the entry count and the output valid; table
// memories need no clearing since only entries below the count are read.
module word_frequency_counter_unit import wfc_pkg::*; #(
  parameter int TABLE_ENTRIES   = DEF_TABLE_ENTRIES,
  parameter int WORD_BUFFER_LEN = DEF_WORD_BUFFER_LEN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // text_byte
  input  logic        s_axis_tlast,  // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // slot, word_count_now, is_new_word, dropped_table_full
);

  cmd_t cmd;
  sts_t sts;

  wfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wfc_datapath #(
    .TABLE_ENTRIES   (TABLE_ENTRIES),
    .WORD_BUFFER_LEN (WORD_BUFFER_LEN)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .text_byte   (s_axis_tdata),
    .end_of_text (s_axis_tlast),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata)
  );

endmodule
